/* hdl/tmps_pkg.sv */
// Shared constants, types and helpers of the triangle path-sum block.
package tmps_pkg;

  localparam int MAX_ROWS = 512;
  localparam int ADDR_W   = $clog2(MAX_ROWS);
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 25;
  localparam int RCNT_W   = 10;
  localparam int RUSE_W   = ADDR_W + 1;

  // Position flags of one entry, decoded when it is accepted.
  typedef struct packed {
    logic              first_row;
    logic              first_col;
    logic              row_end;
    logic              last_row;
    logic [ADDR_W-1:0] col;
  } item_t;

  // Clamp the programmed row count into 1..MAX_ROWS.
  function automatic logic [RUSE_W-1:0] rows_in_use(input logic [RCNT_W-1:0] cnt);
    logic [RUSE_W-1:0] res;
    if (cnt == '0) begin
      res = RUSE_W'(1);
    end else if (int'(cnt) > MAX_ROWS) begin
      res = RUSE_W'(MAX_ROWS);
    end else begin
      res = RUSE_W'(cnt);
    end
    return res;
  endfunction

endpackage

/* hdl/tmps_ifs.sv */
// Valid/ready channel interfaces for triangle entries and path-sum results.
interface tmps_entry_if;
  logic                      valid;
  logic                      ready;
  logic [tmps_pkg::VAL_W-1:0] entry_value;
  modport source (output valid, output entry_value, input ready);
  modport sink   (input valid, input entry_value, output ready);
endinterface

interface tmps_sum_if;
  logic                      valid;
  logic                      ready;
  logic [tmps_pkg::SUM_W-1:0] best_sum;
  modport source (output valid, output best_sum, input ready);
  modport sink   (input valid, input best_sum, output ready);
endinterface

/* hdl/triangle_max_path_sum.sv */
// Top level of the number-triangle maximum path-sum engine.
//
//  channel     | dir | handshake          | payload
//  ------------+-----+--------------------+---------------------------
//  entry_i     | in  | valid/ready        | entry_value [15:0]
//  result_o    | out | valid/ready        | best_sum    [24:0]
//  row_count   | in  | row_count_we_i     | row_count_i [9:0]
//
// One entry per cycle while ready is high: the row-sum memory read is issued at
// the accepting edge, and the add/compare plus write-back happen the next cycle.
// A read that races the write-back of the same column takes the forwarded sum.
// The result goes valid on result_o at the edge that ends that compute cycle.
// Reset is asynchronous; the row-sum memory needs no clearing pass.
// Up to three results may wait on the output; input stalls while the held
// results plus one being pushed now would fill all three places.
module triangle_max_path_sum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        row_count_we_i,
  input  logic [tmps_pkg::RCNT_W-1:0] row_count_i,
  tmps_entry_if.sink                  entry_i,
  tmps_sum_if.source                  result_o
);
  import tmps_pkg::*;

  logic              accept;
  item_t             item;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SUM_W-1:0]  ram_wdata;
  logic [SUM_W-1:0]  ram_rdata;
  logic              push;
  logic [SUM_W-1:0]  push_data;
  logic              pending;
  logic [1:0]        occ;

  // Hold off input while a result in flight might not find a free slot.
  assign entry_i.ready = ({1'b0, occ} + {2'b0, pending}) < 3'd3;
  assign accept        = entry_i.valid && entry_i.ready;

  tmps_pos u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cfg_we_i   (row_count_we_i),
    .cfg_data_i (row_count_i),
    .item_o     (item)
  );

  // Row sums: read the column of the entry being accepted.
  tmps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (item.col),
    .rdata_o (ram_rdata)
  );

  tmps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item),
    .entry_value_i (entry_i.entry_value),
    .cfg_we_i      (row_count_we_i),
    .rdata_i       (ram_rdata),
    .we_o          (ram_we),
    .waddr_o       (ram_waddr),
    .wdata_o       (ram_wdata),
    .push_o        (push),
    .push_data_o   (push_data),
    .pending_o     (pending)
  );

  tmps_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .occ_o       (occ),
    .result_o    (result_o)
  );

endmodule

/* hdl/tmps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module tmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tmps_pos.sv */
// Row/column tracker and row-count register; decodes position flags per entry.
module tmps_pos (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        cfg_we_i,
  input  logic [tmps_pkg::RCNT_W-1:0] cfg_data_i,
  output tmps_pkg::item_t             item_o
);
  import tmps_pkg::*;

  logic [RCNT_W-1:0] row_count_q;
  logic [ADDR_W-1:0] row_q, row_d;
  logic [ADDR_W-1:0] col_q, col_d;
  logic [RUSE_W-1:0] rows;

  assign rows = rows_in_use(row_count_q);

  always_comb begin
    item_o.first_row = (row_q == '0);
    item_o.first_col = (col_q == '0);
    item_o.row_end   = (col_q >= row_q);
    item_o.last_row  = ({1'b0, row_q} + RUSE_W'(1)) >= rows;
    item_o.col       = col_q;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept_i) begin
      if (item_o.row_end) begin
        row_d = item_o.last_row ? '0 : row_q + ADDR_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RCNT_W'(1);
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        row_count_q <= cfg_data_i;
      end
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

/* hdl/tmps_dp.sv */
// Compute stage: read-modify-write of the row-sum memory, forwarding, bottom-row max.
module tmps_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  tmps_pkg::item_t            item_i,
  input  logic [tmps_pkg::VAL_W-1:0] entry_value_i,
  input  logic                       cfg_we_i,
  input  logic [tmps_pkg::SUM_W-1:0] rdata_i,
  output logic                       we_o,
  output logic [tmps_pkg::ADDR_W-1:0] waddr_o,
  output logic [tmps_pkg::SUM_W-1:0] wdata_o,
  output logic                       push_o,
  output logic [tmps_pkg::SUM_W-1:0] push_data_o,
  output logic                       pending_o
);
  import tmps_pkg::*;

  logic             s1_valid_q;
  item_t            s1_q;
  logic [VAL_W-1:0] s1_val_q;
  logic             fwd_q;
  logic [SUM_W-1:0] fwd_sum_q;
  logic [SUM_W-1:0] left_q;
  logic [SUM_W-1:0] bmax_q, bmax_d;
  logic [SUM_W-1:0] above, base, sum;

  always_comb begin
    above = fwd_q ? fwd_sum_q : rdata_i;
    if (s1_q.first_row) begin
      base = '0;
    end else if (s1_q.first_col) begin
      base = above;
    end else if (s1_q.row_end) begin
      base = left_q;
    end else begin
      base = (above > left_q) ? above : left_q;
    end
    sum = base + SUM_W'(s1_val_q);
  end

  always_comb begin
    bmax_d = bmax_q;
    if (s1_q.last_row && (s1_q.first_col || sum >= bmax_q)) begin
      bmax_d = sum;
    end
  end

  assign we_o        = s1_valid_q;
  assign waddr_o     = s1_q.col;
  assign wdata_o     = sum;
  assign push_o      = s1_valid_q && s1_q.row_end && s1_q.last_row;
  assign push_data_o = bmax_d;
  assign pending_o   = push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      bmax_q     <= '0;
    end else begin
      s1_valid_q <= accept_i;
      // Flag a read that races the write-back of the same column.
      fwd_q      <= accept_i && s1_valid_q && (s1_q.col == item_i.col);
      if (cfg_we_i || push_o) begin
        bmax_q <= '0;
      end else if (s1_valid_q) begin
        bmax_q <= bmax_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q     <= item_i;
      s1_val_q <= entry_value_i;
    end
    fwd_sum_q <= sum;
    if (s1_valid_q) begin
      left_q <= above;
    end
  end

  a_fwd_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(s1_valid_q))
    else $error("forward flag without a write-back in the previous cycle");

  a_fwd_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (s1_q.col == $past(s1_q.col)))
    else $error("forwarded column does not match the written column");

  a_push_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> s1_q.last_row && s1_q.row_end)
    else $error("result pushed outside the last entry of the bottom row");

endmodule

/* hdl/tmps_out_buf.sv */
// Three-entry result buffer between the compute stage and the output channel.
module tmps_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [tmps_pkg::SUM_W-1:0] push_data_i,
  output logic [1:0]                 occ_o,
  tmps_sum_if.source                 result_o
);
  import tmps_pkg::*;

  logic [1:0]       occ_q;
  logic [SUM_W-1:0] slot_q [3];
  logic [SUM_W-1:0] slot_d [3];
  logic [1:0]       widx;
  logic             pop;

  assign pop             = result_o.valid && result_o.ready;
  assign result_o.valid  = (occ_q != 2'd0);
  assign result_o.best_sum = slot_q[0];
  assign occ_o           = occ_q;

  // Write behind the last held entry, one place lower when the head leaves.
  assign widx = pop ? (occ_q - 2'd1) : occ_q;

  always_comb begin
    slot_d = slot_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
    if (push_i) begin
      case (widx)
        2'd0:    slot_d[0] = push_data_i;
        2'd1:    slot_d[1] = push_data_i;
        2'd2:    slot_d[2] = push_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 2'd0;
    end else begin
      occ_q <= occ_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop && occ_q == 2'd3))
    else $error("result buffer overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && occ_q == 2'd0))
    else $error("result buffer underflow");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |=> (result_o.valid && $stable(result_o.best_sum)))
    else $error("stalled result changed or dropped");

endmodule
